// ===== design/clock_buffer_replacement_top_macros.svh =====
// Assertion macros used by the slot chooser datapath
`ifndef CLOCK_BUFFER_REPLACEMENT_TOP_MACROS_SVH
`define CLOCK_BUFFER_REPLACEMENT_TOP_MACROS_SVH

// check a property at every rising clock edge outside reset
`define CBR_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("cbr assertion failed");

// check that a condition holds in the cycle after a trigger
`define CBR_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cbr assertion failed");

`endif

// ===== design/cbr_pkg.sv =====
// Shared constants, codes and control types of the buffer slot chooser
package cbr_pkg;

   localparam int NUM_SLOTS_DEFAULT = 64;

   localparam int ACTION_W   = 2;
   localparam int SLOT_IN_W  = 6;
   localparam int SLOT_OUT_W = 6;

   localparam logic [ACTION_W-1:0] ACT_GET     = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_PIN     = 2'd2;

   typedef struct packed {
      logic init_write;
      logic idle;
      logic pop;
      logic sweep_step;
      logic load_rsp;
   } cbr_cmd_type;

   typedef struct packed {
      logic init_last;
      logic req_fire;
      logic req_get;
      logic stack_empty;
      logic victim;
      logic sweep_last;
      logic rsp_free;
   } cbr_stat_type;

endpackage

// ===== design/cbr_req_if.sv =====
// Request channel: action, slot and pin status with valid/ready
interface cbr_req_if;
   logic                           valid;
   logic                           ready;
   logic [cbr_pkg::ACTION_W-1:0]   action;
   logic [cbr_pkg::SLOT_IN_W-1:0]  slot_index;
   logic                           pinned;

   modport source (output valid, action, slot_index, pinned, input ready);
   modport sink (input valid, action, slot_index, pinned, output ready);
endinterface

// ===== design/cbr_rsp_if.sv =====
// Response channel: chosen slot, stack flag and status with valid/ready
interface cbr_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [cbr_pkg::SLOT_OUT_W-1:0]  chosen_slot;
   logic                            from_free_stack;
   logic                            status;

   modport source (output valid, chosen_slot, from_free_stack, status, input ready);
   modport sink (input valid, chosen_slot, from_free_stack, status, output ready);
endinterface

// ===== design/cbr_datapath.sv =====
// Datapath: slot memories, free stack head, clock hand, sweep counter, output register
`include "clock_buffer_replacement_top_macros.svh"
module cbr_datapath #(
   parameter int NUM_SLOTS = cbr_pkg::NUM_SLOTS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   cbr_req_if.sink              req_bus,
   cbr_rsp_if.source            rsp_bus,
   input  cbr_pkg::cbr_cmd_type cmd,
   output cbr_pkg::cbr_stat_type stat
);

   localparam int SLOT_W = $clog2(NUM_SLOTS);
   localparam int PTR_W  = $clog2(NUM_SLOTS + 1);
   localparam int CNT_W  = $clog2(2 * NUM_SLOTS);
   localparam logic [PTR_W-1:0]  EMPTY     = PTR_W'(NUM_SLOTS);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);
   localparam logic [CNT_W-1:0]  LAST_STEP = CNT_W'(2 * NUM_SLOTS - 1);

   logic [PTR_W-1:0]  link_mem [NUM_SLOTS];
   logic              ref_mem  [NUM_SLOTS];
   logic              pin_mem  [NUM_SLOTS];

   logic [PTR_W-1:0]  link_rd_ff;
   logic              ref_rd_ff;
   logic              pin_rd_ff;

   logic [PTR_W-1:0]  head_ff, head_in;
   logic [SLOT_W-1:0] hand_ff, hand_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SLOT_W-1:0] init_ff, init_in;

   logic [cbr_pkg::SLOT_OUT_W-1:0] pend_slot_ff, pend_slot_in;
   logic                           pend_from_ff, pend_from_in;
   logic                           pend_status_ff, pend_status_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [cbr_pkg::SLOT_OUT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic                           rsp_from_ff, rsp_from_in;
   logic                           rsp_status_ff, rsp_status_in;

   logic              req_fire;
   logic              in_range;
   logic [SLOT_W-1:0] req_idx;
   logic [SLOT_W-1:0] hand_next;
   logic              victim;

   logic              link_we;
   logic [SLOT_W-1:0] link_wa;
   logic [PTR_W-1:0]  link_wd;
   logic              ref_we;
   logic [SLOT_W-1:0] ref_wa;
   logic              ref_wd;
   logic              pin_we;
   logic [SLOT_W-1:0] pin_wa;
   logic              pin_wd;

   assign req_bus.ready = cmd.idle;
   assign req_fire      = req_bus.valid && cmd.idle;
   assign in_range      = 32'(req_bus.slot_index) < 32'(NUM_SLOTS);
   assign req_idx       = SLOT_W'(req_bus.slot_index);
   assign hand_next     = (hand_ff == LAST_SLOT) ? '0 : hand_ff + 1'b1;
   assign victim        = !pin_rd_ff && !ref_rd_ff;

   assign stat.init_last   = (init_ff == LAST_SLOT);
   assign stat.req_fire    = req_fire;
   assign stat.req_get     = (req_bus.action == cbr_pkg::ACT_GET);
   assign stat.stack_empty = (head_ff == EMPTY);
   assign stat.victim      = victim;
   assign stat.sweep_last  = (cnt_ff == LAST_STEP);
   assign stat.rsp_free    = !rsp_valid_ff || rsp_bus.ready;

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.chosen_slot     = rsp_slot_ff;
   assign rsp_bus.from_free_stack = rsp_from_ff;
   assign rsp_bus.status          = rsp_status_ff;

   always_comb begin
      link_we = 1'b0;
      link_wa = init_ff;
      link_wd = PTR_W'(init_ff) + 1'b1;
      ref_we  = 1'b0;
      ref_wa  = init_ff;
      ref_wd  = 1'b1;
      pin_we  = 1'b0;
      pin_wa  = init_ff;
      pin_wd  = 1'b0;
      if (cmd.init_write) begin
         link_we = 1'b1;
         ref_we  = 1'b1;
         pin_we  = 1'b1;
      end else if (req_fire && in_range && req_bus.action == cbr_pkg::ACT_RELEASE) begin
         link_we = 1'b1;
         link_wa = req_idx;
         link_wd = head_ff;
      end else if (req_fire && in_range && req_bus.action == cbr_pkg::ACT_PIN) begin
         pin_we = 1'b1;
         pin_wa = req_idx;
         pin_wd = req_bus.pinned;
      end else if (cmd.pop) begin
         link_we = 1'b1;
         link_wa = SLOT_W'(head_ff);
         link_wd = EMPTY;
      end else if (cmd.sweep_step && !pin_rd_ff) begin
         ref_we = 1'b1;
         ref_wa = hand_ff;
         ref_wd = !ref_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      if (ref_we) begin
         ref_mem[ref_wa] <= ref_wd;
      end
      if (pin_we) begin
         pin_mem[pin_wa] <= pin_wd;
      end
      link_rd_ff <= link_mem[SLOT_W'(head_ff)];
      ref_rd_ff  <= ref_mem[hand_ff];
      pin_rd_ff  <= pin_mem[hand_ff];
   end

   always_comb begin
      head_in        = head_ff;
      hand_in        = hand_ff;
      cnt_in         = cnt_ff;
      init_in        = init_ff;
      pend_slot_in   = pend_slot_ff;
      pend_from_in   = pend_from_ff;
      pend_status_in = pend_status_ff;
      if (cmd.init_write && !stat.init_last) begin
         init_in = init_ff + 1'b1;
      end
      if (req_fire) begin
         cnt_in         = '0;
         pend_slot_in   = '0;
         pend_from_in   = 1'b0;
         pend_status_in = 1'b0;
         if (in_range && req_bus.action == cbr_pkg::ACT_RELEASE) begin
            head_in = PTR_W'(req_idx);
         end
      end
      if (cmd.pop) begin
         head_in        = link_rd_ff;
         pend_slot_in   = cbr_pkg::SLOT_OUT_W'(head_ff);
         pend_from_in   = 1'b1;
         pend_status_in = 1'b0;
      end
      if (cmd.sweep_step) begin
         hand_in = hand_next;
         cnt_in  = cnt_ff + 1'b1;
         if (victim) begin
            pend_slot_in   = cbr_pkg::SLOT_OUT_W'(hand_ff);
            pend_from_in   = 1'b0;
            pend_status_in = 1'b0;
         end else if (stat.sweep_last) begin
            pend_slot_in   = '0;
            pend_from_in   = 1'b0;
            pend_status_in = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_slot_in   = rsp_slot_ff;
      rsp_from_in   = rsp_from_ff;
      rsp_status_in = rsp_status_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_slot_in   = pend_slot_ff;
         rsp_from_in   = pend_from_ff;
         rsp_status_in = pend_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         hand_ff      <= '0;
         cnt_ff       <= '0;
         init_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         hand_ff      <= hand_in;
         cnt_ff       <= cnt_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_slot_ff   <= pend_slot_in;
      pend_from_ff   <= pend_from_in;
      pend_status_ff <= pend_status_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_from_ff    <= rsp_from_in;
      rsp_status_ff  <= rsp_status_in;
   end

   `CBR_ASSERT(a_hand_range, PTR_W'(hand_ff) < EMPTY)
   `CBR_ASSERT(a_head_range, head_ff <= EMPTY)
   `CBR_ASSERT(a_fail_payload, rsp_valid_ff && rsp_status_ff |-> rsp_slot_ff == '0 && !rsp_from_ff)
   `CBR_ASSERT_NEXT(a_pop_head, cmd.pop, head_ff == $past(link_rd_ff) && pend_from_ff)

endmodule

// ===== design/cbr_controller.sv =====
// Controller: sequences clearing pass, request decode, stack pop, hand sweep and response load
module cbr_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  cbr_pkg::cbr_stat_type stat,
   output cbr_pkg::cbr_cmd_type  cmd
);

   typedef enum logic [5:0] {
      ST_INIT     = 6'b000001,
      ST_IDLE     = 6'b000010,
      ST_POP      = 6'b000100,
      ST_SWEEP_RD = 6'b001000,
      ST_SWEEP_EV = 6'b010000,
      ST_FINISH   = 6'b100000
   } cbr_state_type;

   cbr_state_type state_ff, state_in;

   always_comb begin
      state_in       = state_ff;
      cmd.init_write = 1'b0;
      cmd.idle       = 1'b0;
      cmd.pop        = 1'b0;
      cmd.sweep_step = 1'b0;
      cmd.load_rsp   = 1'b0;
      case (state_ff)
         ST_INIT: begin
            cmd.init_write = 1'b1;
            if (stat.init_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cmd.idle = 1'b1;
            if (stat.req_fire) begin
               if (!stat.req_get) begin
                  state_in = ST_FINISH;
               end else if (stat.stack_empty) begin
                  state_in = ST_SWEEP_RD;
               end else begin
                  state_in = ST_POP;
               end
            end
         end
         ST_POP: begin
            cmd.pop  = 1'b1;
            state_in = ST_FINISH;
         end
         ST_SWEEP_RD: begin
            state_in = ST_SWEEP_EV;
         end
         ST_SWEEP_EV: begin
            cmd.sweep_step = 1'b1;
            if (stat.victim || stat.sweep_last) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_SWEEP_RD;
            end
         end
         ST_FINISH: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/clock_buffer_replacement_top.sv =====
// Top level of the clock (second chance) buffer slot chooser
// Usage:
//   req_bus carries one item per request: action (get, release, pin),
//   slot_index and pinned. rsp_bus returns exactly one item per request,
//   in request order: chosen_slot, from_free_stack and status.
//   A get pops the free stack when it holds a slot; otherwise the clock
//   hand examines the slots one at a time (memory read, then update).
// Paths from accept to response valid:
//   release, pin or unknown action go straight to the finish state; a get
//   pops the free stack or sweeps the clock hand, and the sweep gives up
//   with status 1 when every slot is pinned.
// Throughput: one item at a time; a new item is taken once the previous
//   one has reached the output register, so a waiting response does not
//   block the next request.
// Reset: synchronous; afterwards a clearing pass over all NUM_SLOTS slots fills
//   the link, reference and pin memories, with req_bus.ready low.
// Stall: a response held by rsp_bus.ready low keeps its payload; the next
//   finished item waits in the controller until the register frees.
module clock_buffer_replacement_top #(
   parameter int NUM_SLOTS = cbr_pkg::NUM_SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   cbr_req_if.sink     req_bus,
   cbr_rsp_if.source   rsp_bus
);

   cbr_pkg::cbr_cmd_type  cmd;
   cbr_pkg::cbr_stat_type stat;

   cbr_controller u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   cbr_datapath #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_dp (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .cmd     (cmd),
      .stat    (stat)
   );

endmodule

// ===== sim/clock_buffer_replacement_top_tb.sv =====
// Self-checking testbench for the clock buffer slot chooser: directed table, random mix, stalls
`timescale 1ns / 100ps

module clock_buffer_replacement_top_tb;

   localparam int SLOTS = cbr_pkg::NUM_SLOTS_DEFAULT;
   localparam logic [6:0] STACK_EMPTY = 7'(SLOTS);
   localparam logic [cbr_pkg::ACTION_W-1:0] ACT_UNKNOWN = 2'd3;
   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int RANDOM_PER_PHASE = 150;
   localparam int HOLD_CYCLES = 250;
   localparam int SETTLE_CYCLES = 20;

   typedef struct packed {
      logic [cbr_pkg::ACTION_W-1:0]  action;
      logic [cbr_pkg::SLOT_IN_W-1:0] slot_index;
      logic                          pinned;
   } slot_request_type;

   typedef struct packed {
      logic [cbr_pkg::SLOT_OUT_W-1:0] chosen_slot;
      logic                           from_free_stack;
      logic                           status;
   } slot_choice_type;

   typedef struct packed {
      slot_request_type req;
      logic             typed;
      slot_choice_type  want;
   } directed_row_type;

   localparam slot_choice_type NO_CHOICE = '0;

   logic clock;
   logic reset;

   cbr_req_if req_bus ();
   cbr_rsp_if rsp_bus ();

   clock_buffer_replacement_top #(
      .NUM_SLOTS (SLOTS)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // slot chooser state mirror
   logic       ref_bit [SLOTS];
   logic       pin_flag [SLOTS];
   logic [5:0] hand;
   logic [6:0] stack_head;
   logic [6:0] stack_link [SLOTS];

   slot_choice_type expected_choices [$];
   int              mismatch_count;
   int              send_idle_pct;
   int              recv_stall_pct;
   bit              hold_request;
   int              hold_left;
   slot_choice_type seen_choice;
   slot_choice_type oldest_choice;

   directed_row_type directed_plan [16] = '{
      '{'{cbr_pkg::ACT_GET,     6'd0,  1'b0}, 1'b1, '{6'd0,  1'b1, 1'b0}},
      '{'{cbr_pkg::ACT_GET,     6'd63, 1'b1}, 1'b1, '{6'd1,  1'b1, 1'b0}},
      '{'{cbr_pkg::ACT_RELEASE, 6'd63, 1'b0}, 1'b1, NO_CHOICE},
      '{'{cbr_pkg::ACT_GET,     6'd0,  1'b0}, 1'b1, '{6'd63, 1'b1, 1'b0}},
      '{'{cbr_pkg::ACT_PIN,     6'd0,  1'b1}, 1'b1, NO_CHOICE},
      '{'{ACT_UNKNOWN,          6'd63, 1'b1}, 1'b1, NO_CHOICE},
      '{'{cbr_pkg::ACT_RELEASE, 6'd0,  1'b1}, 1'b1, NO_CHOICE},
      '{'{cbr_pkg::ACT_GET,     6'd0,  1'b0}, 1'b1, '{6'd0,  1'b1, 1'b0}},
      '{'{cbr_pkg::ACT_RELEASE, 6'd5,  1'b0}, 1'b1, NO_CHOICE},
      '{'{cbr_pkg::ACT_RELEASE, 6'd5,  1'b0}, 1'b1, NO_CHOICE},
      '{'{cbr_pkg::ACT_GET,     6'd0,  1'b0}, 1'b0, NO_CHOICE},
      '{'{cbr_pkg::ACT_GET,     6'd0,  1'b0}, 1'b0, NO_CHOICE},
      '{'{cbr_pkg::ACT_GET,     6'd0,  1'b0}, 1'b0, NO_CHOICE},
      '{'{cbr_pkg::ACT_PIN,     6'd63, 1'b1}, 1'b1, NO_CHOICE},
      '{'{cbr_pkg::ACT_PIN,     6'd0,  1'b0}, 1'b1, NO_CHOICE},
      '{'{cbr_pkg::ACT_GET,     6'd0,  1'b0}, 1'b0, NO_CHOICE}
   };

   always #5 clock = ~clock;

   function automatic void clear_slot_state();
      for (int i = 0; i < SLOTS; i++) begin
         ref_bit[i] = 1'b1;
         pin_flag[i] = 1'b0;
         stack_link[i] = 7'(i + 1);
      end
      stack_link[SLOTS-1] = STACK_EMPTY;
      stack_head = '0;
      hand = '0;
   endfunction

   function automatic slot_choice_type choose_slot(slot_request_type r);
      slot_choice_type c;
      logic [5:0]      h;
      logic            found;
      c = NO_CHOICE;
      found = 1'b0;
      case (r.action)
         cbr_pkg::ACT_GET: begin
            if (stack_head != STACK_EMPTY) begin
               h = stack_head[5:0];
               c.chosen_slot = h;
               c.from_free_stack = 1'b1;
               stack_head = stack_link[h];
               stack_link[h] = STACK_EMPTY;
            end else begin
               c.status = 1'b1;
               for (int n = 0; n < 2 * SLOTS && !found; n++) begin
                  h = hand;
                  if (!pin_flag[h]) begin
                     if (!ref_bit[h]) begin
                        ref_bit[h] = 1'b1;
                        found = 1'b1;
                        c.chosen_slot = h;
                        c.status = 1'b0;
                     end else begin
                        ref_bit[h] = 1'b0;
                     end
                  end
                  hand = (h == 6'(SLOTS - 1)) ? 6'd0 : h + 6'd1;
               end
            end
         end
         cbr_pkg::ACT_RELEASE: begin
            stack_link[r.slot_index] = stack_head;
            stack_head = {1'b0, r.slot_index};
         end
         cbr_pkg::ACT_PIN: begin
            pin_flag[r.slot_index] = r.pinned;
         end
         default: begin
         end
      endcase
      return c;
   endfunction

   function automatic slot_request_type random_request();
      slot_request_type r;
      int               pick;
      pick = $urandom_range(99);
      r.slot_index = cbr_pkg::SLOT_IN_W'($urandom_range(SLOTS - 1));
      r.pinned = 1'($urandom_range(1));
      if (pick < 45) r.action = cbr_pkg::ACT_GET;
      else if (pick < 65) r.action = cbr_pkg::ACT_RELEASE;
      else if (pick < 95) r.action = cbr_pkg::ACT_PIN;
      else r.action = ACT_UNKNOWN;
      return r;
   endfunction

   task automatic note_mismatch(string what, slot_choice_type want, slot_choice_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%t %s: expected %0d %0b %0b, got %0d %0b %0b (slot stack status)",
                  $realtime, what, want.chosen_slot, want.from_free_stack, want.status,
                  got.chosen_slot, got.from_free_stack, got.status);
   endtask

   // called just after a falling edge, returns just after a falling edge
   task automatic send_item(slot_request_type r, logic typed = 1'b0,
                            slot_choice_type want = NO_CHOICE);
      slot_choice_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.action <= r.action;
      req_bus.slot_index <= r.slot_index;
      req_bus.pinned <= r.pinned;
      do @(posedge clock); while (!req_bus.ready);
      predicted = choose_slot(r);
      expected_choices.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   task automatic drain_choices();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (expected_choices.size() != 0);
   endtask

   task automatic start_hold();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      hold_request = 1'b1;
      @(negedge clock);
   endtask

   // empty the stack, pin every slot, ask twice, then unpin about half and ask once more
   task automatic pin_every_slot();
      slot_request_type r;
      for (int k = 0; k < SLOTS + 6 && stack_head != STACK_EMPTY; k++) begin
         r = random_request();
         r.action = cbr_pkg::ACT_GET;
         send_item(r);
      end
      for (int s = 0; s < SLOTS; s++)
         send_item(slot_request_type'{cbr_pkg::ACT_PIN, cbr_pkg::SLOT_IN_W'(s), 1'b1});
      send_item(slot_request_type'{cbr_pkg::ACT_GET, 6'd0, 1'b0});
      send_item(slot_request_type'{cbr_pkg::ACT_GET, 6'd63, 1'b1});
      for (int s = SLOTS - 1; s >= 0; s--)
         send_item(slot_request_type'{cbr_pkg::ACT_PIN, cbr_pkg::SLOT_IN_W'(s),
                                      1'($urandom_range(1))});
      send_item(slot_request_type'{cbr_pkg::ACT_GET, 6'd0, 1'b0});
   endtask

   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen_choice = '{rsp_bus.chosen_slot, rsp_bus.from_free_stack, rsp_bus.status};
         if (expected_choices.size() == 0) begin
            note_mismatch("item with nothing outstanding", NO_CHOICE, seen_choice);
         end else begin
            oldest_choice = expected_choices.pop_front();
            if (seen_choice.chosen_slot !== oldest_choice.chosen_slot ||
                seen_choice.from_free_stack !== oldest_choice.from_free_stack ||
                seen_choice.status !== oldest_choice.status)
               note_mismatch("slot choice mismatch", oldest_choice, seen_choice);
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("clock_buffer_replacement_top test failed");
      $finish;
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.action = cbr_pkg::ACT_GET;
      req_bus.slot_index = '0;
      req_bus.pinned = 1'b0;
      rsp_bus.ready = 1'b0;
      mismatch_count = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_request = 1'b0;
      hold_left = 0;
      clear_slot_state();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_plan[i])
         send_item(directed_plan[i].req, directed_plan[i].typed, directed_plan[i].want);
      drain_choices();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
            default: begin send_idle_pct = 18; recv_stall_pct = 18; end
         endcase
         if (phase == 0) start_hold();
         for (int i = 0; i < RANDOM_PER_PHASE; i++)
            send_item(random_request());
         if (phase == 0 || phase == 2) pin_every_slot();
         drain_choices();
      end

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && expected_choices.size() == 0) begin
         $display("clock_buffer_replacement_top test passed");
      end else begin
         $display("clock_buffer_replacement_top test failed");
      end
      $finish;
   end

endmodule
